[rtl/wpm_pkg.sv]
// Shared constants for the wildcard pattern matcher.
package wpm_pkg;

  localparam int unsigned MAX_PATTERN_DEF = 16;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned SYM_W   = 8;
  localparam int unsigned COUNT_W = 16;

  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_BEGIN  = 2'd1;
  localparam logic [OP_W-1:0] OP_TEXT   = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

  localparam logic [SYM_W-1:0] STAR_BYTE = 8'h2A;
  localparam logic [SYM_W-1:0] ANY_BYTE  = 8'h3F;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

endpackage

[rtl/wpm_in_if.sv]
// Request channel carrying one matcher operation and its byte.
interface wpm_in_if;
  logic                            valid;
  logic                            ready;
  logic [wpm_pkg::OP_W-1:0]        operation;
  logic [wpm_pkg::SYM_W-1:0]       symbol;

  modport source (output valid, output operation, output symbol, input ready);
  modport sink   (input valid, input operation, input symbol, output ready);
endinterface

[rtl/wpm_out_if.sv]
// Result channel carrying the match status after each request.
interface wpm_out_if;
  logic                            valid;
  logic                            ready;
  logic                            matched;
  logic [wpm_pkg::COUNT_W-1:0]     text_length;
  logic                            overflow;

  modport source (output valid, output matched, output text_length, output overflow,
                  input ready);
  modport sink   (input valid, input matched, input text_length, input overflow,
                  output ready);
endinterface

[rtl/wpm_step.sv]
// Shared cell that computes one match bit for one pattern position.
module wpm_step (
  input  logic                       is_text,
  input  logic [wpm_pkg::SYM_W-1:0]  pat,
  input  logic [wpm_pkg::SYM_W-1:0]  sym,
  input  logic                       prev_new,
  input  logic                       old_here,
  input  logic                       old_prev,
  output logic                       bit_new
);

  logic is_star;
  logic hit;

  assign is_star = (pat == wpm_pkg::STAR_BYTE);
  assign hit     = (pat == wpm_pkg::ANY_BYTE) || (pat == sym);

  always_comb begin
    priority if (!is_text) begin
      bit_new = is_star && prev_new;
    end else if (is_star) begin
      bit_new = prev_new || old_here;
    end else if (hit) begin
      bit_new = old_prev;
    end else begin
      bit_new = 1'b0;
    end
  end

endmodule

[rtl/wildcard_pattern_match_core.sv]
// Wildcard pattern matcher top level: sequencer, pattern store and match column.
// Each request (append, begin, clear or text byte) is answered by one result. After a
// request is accepted the block is busy in its start, sweep and finish states and
// takes no new request until idle again. The stored pattern length is 0 to MaxPattern;
// one shared cell walks the match column one pattern position per cycle, fed by the
// pattern store's single registered read port. A waiting result does not hold up the
// next request unless a second result is ready before the first one has been taken.
module wildcard_pattern_match_core #(
  parameter int unsigned MaxPattern = wpm_pkg::MAX_PATTERN_DEF
) (
  input logic       clk,
  input logic       rst_n,
  wpm_in_if.sink    in_chan,
  wpm_out_if.source out_chan
);

  localparam int unsigned LW = $clog2(MaxPattern + 1);
  localparam int unsigned AW = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_START = 2'd1;
  localparam logic [1:0] S_RUN   = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]                    state_r, state_nxt;
  logic [wpm_pkg::OP_W-1:0]      op_r;
  logic [wpm_pkg::SYM_W-1:0]     sym_r;
  logic [LW-1:0]                 len_r;
  logic [LW-1:0]                 idx_r, idx_nxt;
  logic [LW-1:0]                 pos;
  logic [MaxPattern:0]           col_r, col_nxt;
  logic                          prev_old_r, prev_old_nxt;
  logic [wpm_pkg::COUNT_W-1:0]   cnt_r, cnt_nxt;
  logic                          ov_r;
  logic [wpm_pkg::SYM_W-1:0]     mem [MaxPattern];
  logic [wpm_pkg::SYM_W-1:0]     rd_data_r;
  logic                          out_valid_r;
  logic                          out_matched_r;
  logic [wpm_pkg::COUNT_W-1:0]   out_len_r;
  logic                          out_ov_r;
  logic                          accept;
  logic                          full;
  logic                          load_out;
  logic                          bit_new;

  assign in_chan.ready        = (state_r == S_IDLE);
  assign accept               = in_chan.valid && in_chan.ready;
  assign full                 = (len_r == LW'(MaxPattern));
  assign load_out             = (state_r == S_FIN) && (!out_valid_r || out_chan.ready);
  assign pos                  = idx_r + LW'(1);

  assign out_chan.valid       = out_valid_r;
  assign out_chan.matched     = out_matched_r;
  assign out_chan.text_length = out_len_r;
  assign out_chan.overflow    = out_ov_r;

  wpm_step u_step (
    .is_text  (op_r == wpm_pkg::OP_TEXT),
    .pat      (rd_data_r),
    .sym      (sym_r),
    .prev_new (col_r[idx_r]),
    .old_here (col_r[pos]),
    .old_prev (prev_old_r),
    .bit_new  (bit_new)
  );

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    col_nxt      = col_r;
    prev_old_nxt = prev_old_r;
    cnt_nxt      = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_START;
          idx_nxt   = '0;
        end
      end
      S_START: begin
        prev_old_nxt = col_r[0];
        if (op_r == wpm_pkg::OP_TEXT) begin
          col_nxt[0] = 1'b0;
          if (cnt_r != wpm_pkg::COUNT_MAX) begin
            cnt_nxt = cnt_r + wpm_pkg::COUNT_W'(1);
          end
        end else begin
          col_nxt    = '0;
          col_nxt[0] = 1'b1;
          cnt_nxt    = '0;
        end
        state_nxt = (len_r == '0) ? S_FIN : S_RUN;
      end
      S_RUN: begin
        col_nxt[pos] = bit_new;
        prev_old_nxt = col_r[pos];
        idx_nxt      = pos;
        if (pos == len_r) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      col_r       <= {{MaxPattern{1'b0}}, 1'b1};
      cnt_r       <= '0;
      ov_r        <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      prev_old_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      idx_r      <= idx_nxt;
      col_r      <= col_nxt;
      prev_old_r <= prev_old_nxt;
      cnt_r      <= cnt_nxt;
      if (accept) begin
        if (in_chan.operation == wpm_pkg::OP_APPEND) begin
          if (full) begin
            ov_r <= 1'b1;
          end else begin
            len_r <= len_r + LW'(1);
          end
        end else if (in_chan.operation == wpm_pkg::OP_CLEAR) begin
          len_r <= '0;
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_chan.operation;
      sym_r <= in_chan.symbol;
    end
    if (load_out) begin
      out_matched_r <= col_r[len_r];
      out_len_r     <= cnt_r;
      out_ov_r      <= ov_r;
    end
  end

  // The pattern store is read one position ahead of the sweep.
  always_ff @(posedge clk) begin
    if (accept && (in_chan.operation == wpm_pkg::OP_APPEND) && !full) begin
      mem[len_r[AW-1:0]] <= in_chan.symbol;
    end
    rd_data_r <= mem[idx_nxt[AW-1:0]];
  end

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(MaxPattern))
    else $error("pattern length exceeds the store");

  a_run_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (idx_r < len_r))
    else $error("sweep index ran past the pattern length");

  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_START))
    else $error("accepted request did not start the sweep");

  a_ov_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |=> ov_r)
    else $error("overflow flag cleared without reset");

  a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_chan.ready && !load_out) |=> !out_valid_r)
    else $error("taken result was presented again");

endmodule
